// File: rtl/mema_pkg.sv
// Package for the mesh edge adjacency matcher: table sizes, beat and table word types,
// memory request struct and the key hash. No dependencies.
package mema_pkg;

  localparam int unsigned TableEntries = 4096;  // power of two
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned CntW         = $clog2(TableEntries + 1);
  localparam int unsigned KeyW         = 192;
  localparam int unsigned OwnW         = 20;
  localparam int unsigned StW          = 2;
  localparam int unsigned WordW        = StW + OwnW + KeyW;

  localparam logic [StW-1:0] StEmpty = 2'd0;
  localparam logic [StW-1:0] StUsed  = 2'd1;
  localparam logic [StW-1:0] StTomb  = 2'd2;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic [17:0]        triangle;
    logic [1:0]         edge_slot;
  } edge_t;

  typedef struct packed {
    logic        matched;
    logic [17:0] this_triangle;
    logic [1:0]  this_edge;
    logic [17:0] partner_triangle;
    logic [1:0]  partner_edge;
    logic        table_full;
    logic [12:0] open_edges;
  } result_t;

  typedef struct packed {
    logic [StW-1:0]  status;
    logic [OwnW-1:0] owner;
    logic [KeyW-1:0] key;
  } word_t;

  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [WordW-1:0] wdata;
    logic [IdxW-1:0]  raddr;
  } mem_req_t;

  function automatic logic [IdxW-1:0] hash_key(input logic [KeyW-1:0] key);
    logic [IdxW-1:0] h;
    h = '0;
    for (int i = 0; i < KeyW; i++) begin
      h[i % IdxW] = h[i % IdxW] ^ key[i];
    end
    return h;
  endfunction

endpackage

// File: rtl/mema_if.sv
// Valid/ready channel interfaces for edge beats and result beats.
// Depends on mema_pkg.
interface mema_edge_if;
  logic            valid;
  logic            ready;
  mema_pkg::edge_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mema_result_if;
  logic              valid;
  logic              ready;
  mema_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/mema_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mema_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: rtl/mema_ctrl.sv
// Probe sequencer: clearing pass, hashed linear probe, match/insert write-back, result register.
// Depends on mema_pkg and mema_if.
module mema_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mema_edge_if.sink             edge_i,
  mema_result_if.source         result_o,
  output mema_pkg::mem_req_t    mem_req_o,
  input  logic [mema_pkg::WordW-1:0] mem_rdata_i
);
  import mema_pkg::*;

  localparam logic [2:0] SClr   = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SRead  = 3'd2;
  localparam logic [2:0] SCheck = 3'd3;
  localparam logic [2:0] SFin   = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] clr_idx_q, clr_idx_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] probes_q, probes_d;
  logic [CntW-1:0] count_q, count_d;
  logic            free_ok_q, free_ok_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic            match_q, match_d;
  logic [OwnW-1:0] part_q, part_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [OwnW-1:0] owner_q, owner_d;
  logic            out_valid_q, out_valid_d;
  result_t         out_q, out_d;

  word_t rd_w, wr_w;
  logic  a_below;
  logic [95:0] pa, pb, lo, hi;

  assign rd_w = word_t'(mem_rdata_i);

  always_comb begin
    pa = {edge_i.data.first_x, edge_i.data.first_y, edge_i.data.first_z};
    pb = {edge_i.data.second_x, edge_i.data.second_y, edge_i.data.second_z};
    a_below = (pa ^ {3{32'h8000_0000}}) < (pb ^ {3{32'h8000_0000}});
    lo = a_below ? pa : pb;
    hi = a_below ? pb : pa;
  end

  assign edge_i.ready   = (state_q == SIdle);
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    idx_d       = idx_q;
    probes_d    = probes_q;
    count_d     = count_q;
    free_ok_d   = free_ok_q;
    free_idx_d  = free_idx_q;
    match_d     = match_q;
    part_d      = part_q;
    key_d       = key_q;
    owner_d     = owner_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_d       = out_q;
    wr_w        = '{status: StEmpty, owner: owner_q, key: key_q};
    mem_req_o   = '{we: 1'b0, waddr: idx_q, wdata: WordW'(wr_w), raddr: idx_q};

    case (state_q)
      SClr: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_idx_q;
        if (clr_idx_q == IdxW'(TableEntries - 1)) begin
          state_d = SIdle;
        end else begin
          clr_idx_d = clr_idx_q + 1'b1;
        end
      end
      SIdle: begin
        if (edge_i.valid) begin
          key_d     = {lo, hi};
          owner_d   = {edge_i.data.triangle, edge_i.data.edge_slot};
          idx_d     = hash_key({lo, hi});
          probes_d  = '0;
          free_ok_d = 1'b0;
          match_d   = 1'b0;
          part_d    = '0;
          state_d   = SRead;
        end
      end
      SRead: begin
        state_d = SCheck;
      end
      SCheck: begin
        if (rd_w.status == StUsed && rd_w.key == key_q) begin
          match_d = 1'b1;
          part_d  = rd_w.owner;
          state_d = SFin;
        end else if (rd_w.status == StEmpty) begin
          if (!free_ok_q) begin
            free_ok_d  = 1'b1;
            free_idx_d = idx_q;
          end
          state_d = SFin;
        end else begin
          if (rd_w.status != StUsed && !free_ok_q) begin
            free_ok_d  = 1'b1;
            free_idx_d = idx_q;
          end
          if (probes_q == CntW'(TableEntries - 1)) begin
            state_d = SFin;
          end else begin
            probes_d = probes_q + 1'b1;
            idx_d    = idx_q + 1'b1;
            state_d  = SRead;
          end
        end
      end
      SFin: begin
        if (!out_valid_q || result_o.ready) begin
          out_d.matched          = match_q;
          out_d.this_triangle    = owner_q[OwnW-1:2];
          out_d.this_edge        = owner_q[1:0];
          out_d.partner_triangle = part_q[OwnW-1:2];
          out_d.partner_edge     = part_q[1:0];
          out_d.table_full       = 1'b0;
          if (match_q) begin
            wr_w.status     = StTomb;
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = idx_q;
            count_d         = count_q - 1'b1;
          end else if (count_q >= CntW'(TableEntries) || !free_ok_q) begin
            out_d.table_full = 1'b1;
          end else begin
            wr_w.status     = StUsed;
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = free_idx_q;
            count_d         = count_q + 1'b1;
          end
          mem_req_o.wdata  = WordW'(wr_w);
          out_d.open_edges = 13'(count_d);
          out_valid_d      = 1'b1;
          state_d          = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClr;
      clr_idx_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      free_ok_q   <= 1'b0;
      match_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      free_ok_q   <= free_ok_d;
      match_q     <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    probes_q   <= probes_d;
    free_idx_q <= free_idx_d;
    part_q     <= part_d;
    key_q      <= key_d;
    owner_q    <= owner_d;
    out_q      <= out_d;
  end
endmodule

// File: rtl/mesh_edge_adjacency_matcher_core.sv
// Mesh edge adjacency matcher, top level: probe sequencer plus the edge table RAM.
// Depends on mema_pkg, mema_if, mema_ram and mema_ctrl.
//
// Edges are matched in a hashed table of 4096 entries held in one RAM with linear
// probing and tombstones. After reset a clearing pass empties the table; no edge beat
// is taken during it. Each edge is then accepted, each probed entry takes a RAM read
// then a compare, and a final step does the write-back and the result. The probe
// stops at a match, at an empty entry or after walking the whole table. One edge is
// in flight at a time; a finished result waits in the output register while the next
// beat is taken.
module mesh_edge_adjacency_matcher_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  mema_edge_if.sink     edge_i,
  mema_result_if.source result_o
);
  import mema_pkg::*;

  mem_req_t         mem_req;
  logic [WordW-1:0] mem_rdata;

  mema_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .edge_i      (edge_i),
    .result_o    (result_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  mema_ram #(
    .Width (WordW),
    .Depth (TableEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );
endmodule

// File: test/mema_checker.sv
// Checker for the mesh edge adjacency matcher: watches both channels, predicts every
// result beat from an open-edge table of its own and compares field by field.
// Depends on mema_pkg and mema_if.
module mema_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  mema_edge_if   edge_mon,
  mema_result_if result_mon,
  output int     fail_count,
  output int     pending_count,
  output int     open_count
);
  import mema_pkg::*;

  logic [OwnW-1:0] open_table [logic [KeyW-1:0]];
  result_t         expected_q [$];

  assign pending_count = expected_q.size();
  assign open_count    = open_table.num();

  function automatic logic first_is_low(edge_t e);
    if (e.first_x != e.second_x) return $signed(e.first_x) < $signed(e.second_x);
    if (e.first_y != e.second_y) return $signed(e.first_y) < $signed(e.second_y);
    return $signed(e.first_z) < $signed(e.second_z);
  endfunction

  function automatic result_t match_edge(edge_t e);
    result_t         r;
    logic [KeyW-1:0] key;
    if (first_is_low(e)) begin
      key = {e.first_x, e.first_y, e.first_z, e.second_x, e.second_y, e.second_z};
    end else begin
      key = {e.second_x, e.second_y, e.second_z, e.first_x, e.first_y, e.first_z};
    end
    r = '0;
    r.this_triangle = e.triangle;
    r.this_edge     = e.edge_slot;
    if (open_table.exists(key)) begin
      r.matched          = 1'b1;
      r.partner_triangle = open_table[key][OwnW-1:2];
      r.partner_edge     = open_table[key][1:0];
      open_table.delete(key);
    end else if (open_table.num() >= TableEntries) begin
      r.table_full = 1'b1;
    end else begin
      open_table[key] = {e.triangle, e.edge_slot};
    end
    r.open_edges = 13'(open_table.num());
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;

  // sampled mid-cycle; the beat moves at the next rising edge
  always @(negedge clk_i) begin
    result_t got, want;
    if (rst_ni && edge_mon.valid && edge_mon.ready) begin
      expected_q.push_back(match_edge(edge_mon.data));
    end
    if (rst_ni && result_mon.valid && result_mon.ready) begin
      got = result_mon.data;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.matched !== want.matched)
          report_mismatch("matched", got.matched, want.matched);
        if (got.this_triangle !== want.this_triangle)
          report_mismatch("this_triangle", got.this_triangle, want.this_triangle);
        if (got.this_edge !== want.this_edge)
          report_mismatch("this_edge", got.this_edge, want.this_edge);
        if (got.partner_triangle !== want.partner_triangle)
          report_mismatch("partner_triangle", got.partner_triangle, want.partner_triangle);
        if (got.partner_edge !== want.partner_edge)
          report_mismatch("partner_edge", got.partner_edge, want.partner_edge);
        if (got.table_full !== want.table_full)
          report_mismatch("table_full", got.table_full, want.table_full);
        if (got.open_edges !== want.open_edges)
          report_mismatch("open_edges", got.open_edges, want.open_edges);
      end
    end
  end

endmodule

// File: test/testbench.sv
// Top of the matcher testbench: clock, reset, edge stimulus, result back-pressure,
// watchdog and verdict. Depends on mema_pkg, mema_if, mema_checker and the core.
module testbench;
  import mema_pkg::*;

  localparam int IdleLimit = 60000;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  int    fail_count, pending_count, open_count;
  int    quiet_cycles = 0;
  int    sent_count = 0;
  edge_t recent_edges [$];

  mema_edge_if   edge_ch ();
  mema_result_if result_ch ();

  mesh_edge_adjacency_matcher_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .edge_i   (edge_ch),
    .result_o (result_ch)
  );

  mema_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .edge_mon      (edge_ch),
    .result_mon    (result_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .open_count    (open_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result side: random stalls, one long hold-off, one stretch with no stalls
  initial begin
    int rx_cycles;
    rx_cycles = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cycles++;
      if (rx_cycles >= 6000 && rx_cycles < 6400) begin
        result_ch.ready <= 1'b0;
      end else if (rx_cycles >= 8000 && rx_cycles < 9500) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= 34);
      end
    end
  end

  always @(negedge clk_i) begin
    if ((edge_ch.valid && edge_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_edge(edge_t e);
    while (!(sent_count >= 400 && sent_count < 600) && $urandom_range(99) < 34) begin
      edge_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    edge_ch.valid <= 1'b1;
    edge_ch.data  <= e;
    do @(negedge clk_i); while (!edge_ch.ready);
    @(posedge clk_i);
    sent_count++;
    recent_edges.push_back(e);
    if (recent_edges.size() > 64) void'(recent_edges.pop_front());
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return 32'($signed($urandom_range(6)) - 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic edge_t make_edge(logic [31:0] ax, ay, az, bx, by, bz,
                                      logic [17:0] tri_id, logic [1:0] slot);
    edge_t e;
    e.first_x = ax; e.first_y = ay; e.first_z = az;
    e.second_x = bx; e.second_y = by; e.second_z = bz;
    e.triangle = tri_id; e.edge_slot = slot;
    return e;
  endfunction

  // keys (0,0,0)-(0,0,v) hash straight to v, which keeps the table fill cheap
  function automatic edge_t fill_edge(int v, logic flip);
    if (flip) return make_edge(0, 0, v, 0, 0, 0, 18'($urandom), 2'($urandom));
    return make_edge(0, 0, 0, 0, 0, v, 18'($urandom), 2'($urandom));
  endfunction

  function automatic edge_t random_edge();
    edge_t e;
    int    sel;
    logic [31:0] t;
    sel = $urandom_range(99);
    if (sel < 45 && recent_edges.size() > 0) begin
      e = recent_edges[$urandom_range(recent_edges.size() - 1)];
      if ($urandom_range(1)) begin
        t = e.first_x; e.first_x = e.second_x; e.second_x = t;
        t = e.first_y; e.first_y = e.second_y; e.second_y = t;
        t = e.first_z; e.first_z = e.second_z; e.second_z = t;
      end
    end else if (sel < 55) begin
      e.first_x = pick_coord(); e.first_y = pick_coord(); e.first_z = pick_coord();
      e.second_x = e.first_x; e.second_y = e.first_y; e.second_z = e.first_z;
    end else begin
      e.first_x = pick_coord(); e.first_y = pick_coord(); e.first_z = pick_coord();
      e.second_x = pick_coord(); e.second_y = pick_coord(); e.second_z = pick_coord();
      if (e.first_x == 0 && e.first_y == 0 && e.second_x == 0 && e.second_y == 0)
        e.first_x = 32'd9;
    end
    e.triangle  = ($urandom_range(9) == 0) ? 18'h3ffff : 18'($urandom);
    e.edge_slot = 2'($urandom);
    return e;
  endfunction

  initial begin
    int base;
    edge_ch.valid = 1'b0;
    edge_ch.data  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, degenerate edges, slot 3, reversed and repeated matches
    send_edge(make_edge(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 18'd0, 2'd0));
    send_edge(make_edge(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 18'h3ffff, 2'd3));
    send_edge(make_edge(5, 5, 5, 5, 5, 5, 18'h3ffff, 2'd3));
    send_edge(make_edge(5, 5, 5, 5, 5, 5, 18'd1, 2'd1));
    send_edge(make_edge(-1, 2, 3, 1, 2, 3, 18'd2, 2'd2));
    send_edge(make_edge(-1, 2, 3, 1, 2, 3, 18'd3, 2'd0));
    send_edge(make_edge(-1, 2, 3, 1, 2, 3, 18'd4, 2'd1));
    send_edge(make_edge(4, -7, 1, 4, 7, 1, 18'h2aaaa, 2'd1));
    send_edge(make_edge(4, 7, 1, 4, -7, 1, 18'h15555, 2'd2));
    send_edge(make_edge(4, 7, -1, 4, 7, 1, 18'd6, 2'd3));
    send_edge(make_edge(4, 7, 1, 4, 7, -1, 18'd7, 2'd3));
    send_edge(make_edge(32'hffff_ffff, 0, 0, 0, 32'hffff_ffff, 0, 18'd8, 2'd0));
    send_edge(make_edge(32'h8000_0000, 32'h7fff_ffff, 0, 32'h8000_0000,
                        32'h8000_0000, 0, 18'd9, 2'd2));

    repeat (1250) send_edge(random_edge());

    // fill the table to its limit, overflow it, match while full, refill
    edge_ch.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    base = open_count;
    for (int v = 0; v < 4096 - base; v++) send_edge(fill_edge(v, 1'b0));
    send_edge(fill_edge(5000, 1'b0));
    send_edge(fill_edge(6000, 1'b1));
    send_edge(fill_edge(7, 1'b1));
    send_edge(fill_edge(5000, 1'b1));
    send_edge(fill_edge(6001, 1'b0));
    send_edge(fill_edge(3, 1'b1));
    edge_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
